FILE: rtl/htpt_pkg.sv
// Shared types, constants and helpers for the hysteresis turning-point tracker.
package htpt_pkg;

    // Q1.15 saturation of 1.0
    localparam logic [15:0] SAT_ONE = 16'h8000;

    // Number of turning-point stack entries
    localparam int STACK_DEPTH = 4;

    // Input commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_START_ORDER  = 3'd0;
    localparam logic [2:0] REG_START_TURN_A = 3'd1;
    localparam logic [2:0] REG_START_TURN_B = 3'd2;
    localparam logic [2:0] REG_START_TURN_C = 3'd3;
    localparam logic [2:0] REG_START_TURN_D = 3'd4;

    typedef struct packed {
        logic        command;
        logic [15:0] sat_new;
        logic [15:0] sat_prev;
    } htpt_in_t;

    typedef struct packed {
        logic [2:0]  order;
        logic [15:0] turn_a;
        logic [15:0] turn_b;
        logic [15:0] turn_c;
        logic [15:0] turn_d;
    } htpt_out_t;

    // Start values held in the configuration registers
    typedef struct packed {
        logic [2:0]                        start_order;
        logic [STACK_DEPTH-1:0][15:0]      start_turn;
    } htpt_cfg_t;

    // Result of the shared magnitude compare
    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } htpt_cmp_t;

    // Limit a Q1.15 saturation to 1.0
    function automatic logic [15:0] sat_clamp(input logic [15:0] v);
        sat_clamp = (v > SAT_ONE) ? SAT_ONE : v;
    endfunction

endpackage

FILE: rtl/htpt_cmp.sv
// Shared unsigned magnitude comparator used by all compare states of the sequencer.
module htpt_cmp (
    input  logic [15:0]       a,
    input  logic [15:0]       b,
    output htpt_pkg::htpt_cmp_t res
);

    // One subtract-style compare, three flags
    always_comb
    begin
        res.lt = (a < b);
        res.eq = (a == b);
        res.gt = (a > b);
    end

endmodule

FILE: rtl/htpt_core.sv
// Sequencer, order register and turning-point stack of the tracker.
module htpt_core #(
    parameter int MAX_ORDER = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  htpt_pkg::htpt_in_t     item,
    input  htpt_pkg::htpt_cfg_t    cfg,
    input  logic                   ack,
    output logic                   idle,
    output logic                   done,
    output htpt_pkg::htpt_out_t    res
);

    localparam logic [2:0] MaxOrd = 3'(MAX_ORDER);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_REV,
        S_LAST,
        S_DROP,
        S_DONE
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  order_reg, order_next;
    logic        drop_cnt_reg, drop_cnt_next;
    logic [15:0] sat_new_reg, sat_prev_reg;
    logic [15:0] stack_reg [htpt_pkg::STACK_DEPTH];

    logic [1:0]          rd_idx;
    logic [15:0]         cmp_b;
    htpt_pkg::htpt_cmp_t cmp_res;
    logic                even;
    logic                push_en;
    logic [2:0]          load_n;

    // Operand select for the shared compare
    always_comb
    begin
        rd_idx = (state_reg == S_LAST) ? (order_reg[1:0] - 2'd1) : (order_reg[1:0] - 2'd2);
        cmp_b  = (state_reg == S_REV) ? sat_prev_reg : stack_reg[rd_idx];
    end

    htpt_cmp u_cmp (
        .a   (sat_new_reg),
        .b   (cmp_b),
        .res (cmp_res)
    );

    assign even   = ~order_reg[0];
    assign load_n = (cfg.start_order > MaxOrd) ? MaxOrd : cfg.start_order;
    assign push_en = (state_reg == S_REV) && (order_reg < MaxOrd) &&
                     (even ? cmp_res.gt : cmp_res.lt);

    // Next-state and order update
    always_comb
    begin
        state_next    = state_reg;
        order_next    = order_reg;
        drop_cnt_next = drop_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    drop_cnt_next = 1'b0;
                    state_next = (item.command == htpt_pkg::CMD_LOAD) ? S_LOAD : S_REV;
                end
            end
            S_LOAD:
            begin
                order_next = load_n;
                state_next = S_DONE;
            end
            S_REV:
            begin
                // reversal pushes, saturation at 1.0 wipes the order
                if (sat_new_reg == htpt_pkg::SAT_ONE)
                    order_next = 3'd0;
                else if (push_en)
                    order_next = order_reg + 3'd1;
                state_next = S_LAST;
            end
            S_LAST:
            begin
                // crossing the last turning point at full order
                if ((order_reg == MaxOrd) &&
                    (even ? (cmp_res.gt || cmp_res.eq) : (cmp_res.lt || cmp_res.eq)))
                    order_next = order_reg - 3'd1;
                state_next = S_DROP;
            end
            S_DROP:
            begin
                // crossing the second-to-last point closes a loop, at most twice
                if ((order_reg > 3'd1) &&
                    (even ? (cmp_res.lt || cmp_res.eq) : (cmp_res.gt || cmp_res.eq)))
                begin
                    order_next = order_reg - 3'd2;
                    if (drop_cnt_reg)
                        state_next = S_DONE;
                    else
                        drop_cnt_next = 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (ack)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            order_reg    <= 3'd0;
            drop_cnt_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            order_reg    <= order_next;
            drop_cnt_reg <= drop_cnt_next;
        end
    end

    // Captured saturations, clamped to 1.0
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            sat_new_reg  <= htpt_pkg::sat_clamp(item.sat_new);
            sat_prev_reg <= htpt_pkg::sat_clamp(item.sat_prev);
        end
    end

    // Turning-point stack: bulk load or single push
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
        begin
            for (int i = 0; i < htpt_pkg::STACK_DEPTH; i++)
            begin
                if (3'(i) < load_n)
                    stack_reg[i] <= htpt_pkg::sat_clamp(cfg.start_turn[i]);
            end
        end
        else if (push_en)
        begin
            stack_reg[order_reg[1:0]] <= sat_prev_reg;
        end
    end

    assign idle       = (state_reg == S_IDLE);
    assign done       = (state_reg == S_DONE);
    assign res.order  = order_reg;
    assign res.turn_a = stack_reg[0];
    assign res.turn_b = stack_reg[1];
    assign res.turn_c = stack_reg[2];
    assign res.turn_d = stack_reg[3];

endmodule

FILE: rtl/hysteresis_turning_point_tracker_unit.sv
// Top level of the hysteresis turning-point tracker: config, handshakes, result register.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------
//   in       | in_valid / in_ready  | in_data  (command, sat_new, sat_prev)
//   out      | out_valid / out_ready| out_data (order, turn_a..turn_d)
//   cfg      | cfg_en (no wait)     | cfg_addr, cfg_data
//
// A load transaction passes from accept through the load state to the result
// register; a step runs reversal, last-point and one or two drop compares,
// all through the one shared comparator. in_ready is high only while the
// sequencer is idle; a finished result waits in the output register, so a new
// transaction is taken while out_ready is low. Reset clears order and config.
module hysteresis_turning_point_tracker_unit #(
    parameter int MAX_ORDER = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  htpt_pkg::htpt_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output htpt_pkg::htpt_out_t out_data,
    input  logic                cfg_en,
    input  logic [2:0]          cfg_addr,
    input  logic [15:0]         cfg_data
);

    localparam logic [2:0] MaxOrd = 3'(MAX_ORDER);

    htpt_pkg::htpt_cfg_t cfg_reg;
    htpt_pkg::htpt_out_t out_data_reg;
    htpt_pkg::htpt_out_t core_res;
    logic                out_valid_reg;
    logic                core_idle;
    logic                core_done;
    logic                core_ack;
    logic                in_accept;

    assign in_accept = in_valid && in_ready;
    assign core_ack  = core_done && (!out_valid_reg || out_ready);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_en)
        begin
            case (cfg_addr)
                htpt_pkg::REG_START_ORDER:  cfg_reg.start_order   <= cfg_data[2:0];
                htpt_pkg::REG_START_TURN_A: cfg_reg.start_turn[0] <= cfg_data;
                htpt_pkg::REG_START_TURN_B: cfg_reg.start_turn[1] <= cfg_data;
                htpt_pkg::REG_START_TURN_C: cfg_reg.start_turn[2] <= cfg_data;
                htpt_pkg::REG_START_TURN_D: cfg_reg.start_turn[3] <= cfg_data;
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    htpt_core #(
        .MAX_ORDER (MAX_ORDER)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_accept),
        .item  (in_data),
        .cfg   (cfg_reg),
        .ack   (core_ack),
        .idle  (core_idle),
        .done  (core_done),
        .res   (core_res)
    );

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (core_ack)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (core_ack)
            out_data_reg <= core_res;
    end

    assign in_ready  = core_idle;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // Sequencer goes busy right after taking a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ready)
        else $error("in_ready still high after accept");

    // Order never exceeds the maximum
    a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
        core_res.order <= MaxOrd)
        else $error("order above MAX_ORDER");

    // A new result appears only from a finished sequence
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(core_done))
        else $error("result register loaded without a finished sequence");

    // Results leave the sequencer only when it is done; it is idle after the handoff
    a_ack_done: assert property (@(posedge clk) disable iff (!rst_n)
        core_ack |=> core_idle)
        else $error("sequencer not idle after result handoff");
`endif

endmodule
